[rtl/cbam_pkg.sv]
// Shared types, widths and codes for the cartridge bank address mapper.
// No dependencies; every other file imports this package.
package cbam_pkg;

    // Window geometry
    localparam int PRG_WINDOW_SLOTS = 4;
    localparam int CHR_WINDOW_SLOTS = 8;
    localparam int PRG_IDX_W        = $clog2(PRG_WINDOW_SLOTS);
    localparam int CHR_IDX_W        = $clog2(CHR_WINDOW_SLOTS);
    localparam int WR_IDX_W         = (PRG_IDX_W > CHR_IDX_W) ? PRG_IDX_W : CHR_IDX_W;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int CODE_W   = 2;
    localparam int SLOT_W   = 3;
    localparam int BANK_W   = 13;
    localparam int ADDR_W   = 16;
    localparam int TARGET_W = 2;
    localparam int OFFSET_W = 22;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;

    // Page units: program windows are 8 KB, pattern windows 1 KB
    localparam int PRG_UNIT_W = 13;
    localparam int CHR_UNIT_W = 10;

    // Table entries hold offsets in page units (below 2*255 and 8*255)
    localparam int PRG_ENT_W = 9;
    localparam int CHR_ENT_W = 11;

    // Remainder unit
    localparam int VAL_W  = 17;   // signed bank value in page units
    localparam int MAG_W  = 16;   // magnitude of that value
    localparam int DIV_W  = 11;   // ROM size in page units
    localparam int REM_W  = 12;   // partial remainder
    localparam int STEP_W = $clog2(MAG_W);
    localparam int SPAN_W = 7;    // (slot + 1) << code
    localparam int LEFT_W = 4;    // entries left to write

    localparam logic [ADDR_W-1:0] PRG_BASE = 16'h8000;
    localparam logic [ADDR_W-1:0] RAM_BASE = 16'h6000;
    localparam logic [CODE_W-1:0] PRG_CODE_BAD = 2'd3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_MAP_PRG  = 2'd0,
        ACT_MAP_CHR  = 2'd1,
        ACT_CPU_READ = 2'd2,
        ACT_CHR_READ = 2'd3
    } t_action;

    typedef enum logic [TARGET_W-1:0] {
        TGT_PRG_ROM  = 2'd0,
        TGT_PRG_RAM  = 2'd1,
        TGT_CHR      = 2'd2,
        TGT_UNMAPPED = 2'd3
    } t_target;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRG_BANKS = 1'd0,
        CFG_CHR_BANKS = 1'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_READ  = 3'd1,
        ST_DIV   = 3'd2,
        ST_FIX   = 3'd3,
        ST_WRITE = 3'd4
    } t_state;

    typedef struct packed {
        logic load_item;
        logic div_step;
        logic fix;
        logic write_slot;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_is_read;
        logic map_ok;
        logic div_last;
        logic write_last;
        logic out_free;
    } t_stat;

endpackage

[rtl/cbam_ifs.sv]
// Valid/ready channel interfaces: input words, result words and register writes.
// Depends on cbam_pkg for the field widths.
interface cbam_in_if import cbam_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ACTION_W-1:0]      action;
    logic [CODE_W-1:0]        page_size_code;
    logic [SLOT_W-1:0]        slot;
    logic signed [BANK_W-1:0] bank;
    logic [ADDR_W-1:0]        address;

    modport source (output valid, action, page_size_code, slot, bank, address, input ready);
    modport sink   (input valid, action, page_size_code, slot, bank, address, output ready);
endinterface

interface cbam_out_if import cbam_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TARGET_W-1:0] target;
    logic [OFFSET_W-1:0] offset;

    modport source (output valid, target, offset, input ready);
    modport sink   (input valid, target, offset, output ready);
endinterface

interface cbam_cfg_if import cbam_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/cbam_datapath.sv]
// Datapath: size registers, window tables, remainder unit and result register.
// Depends on cbam_pkg and the channel interfaces in cbam_ifs.sv.
module cbam_datapath import cbam_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    cbam_in_if.sink    i_item,
    cbam_out_if.source o_result,
    cbam_cfg_if.sink   i_cfg
);

    logic [CFG_W-1:0]     r_prg_banks;
    logic [CFG_W-1:0]     r_chr_banks;
    logic [PRG_ENT_W-1:0] r_prg_tab [PRG_WINDOW_SLOTS];
    logic [CHR_ENT_W-1:0] r_chr_tab [CHR_WINDOW_SLOTS];

    t_action              r_action;
    logic [ADDR_W-1:0]    r_addr;
    logic                 r_is_prg;
    logic                 r_map_ok;
    logic [MAG_W-1:0]     r_mag;
    logic                 r_neg;
    logic [DIV_W-1:0]     r_div;
    logic [REM_W-1:0]     r_rem;
    logic [STEP_W-1:0]    r_step;
    logic [WR_IDX_W-1:0]  r_wr_idx;
    logic [LEFT_W-1:0]    r_left;

    logic                 r_out_valid;
    t_target              r_out_target;
    logic [OFFSET_W-1:0]  r_out_offset;

    // Item decode at accept
    t_action                 w_in_action;
    logic [CFG_W-1:0]        w_prg_n;
    logic [CFG_W-1:0]        w_chr_n;
    logic [CFG_W:0]          w_prg_size;
    logic [CFG_W:0]          w_adj;
    logic signed [VAL_W-1:0] w_bank;
    logic signed [VAL_W-1:0] w_base;
    logic signed [VAL_W-1:0] w_val;
    logic signed [VAL_W-1:0] w_val_neg;
    logic [SPAN_W-1:0]       w_span_end;
    logic [SPAN_W-1:0]       w_span_first;
    logic                    w_map_ok;

    // Remainder unit
    logic [REM_W-1:0]        w_rem_sh;
    logic [REM_W-1:0]        w_div_ext;
    logic [REM_W-1:0]        w_rem_step;
    logic [REM_W-1:0]        w_rem_inc;

    // Read translation
    logic [ADDR_W-PRG_UNIT_W-2:0] w_prg_sel;
    logic [ADDR_W-CHR_UNIT_W-1:0] w_chr_sel;
    t_target                      w_target;
    logic [OFFSET_W-1:0]          w_offset;
    logic                         w_out_free;

    assign w_in_action = t_action'(i_item.action);
    assign w_prg_n     = (r_prg_banks == '0) ? CFG_W'(1) : r_prg_banks;
    assign w_chr_n     = (r_chr_banks == '0) ? CFG_W'(1) : r_chr_banks;
    assign w_prg_size  = {w_prg_n, 1'b0};
    assign w_adj       = w_prg_size >> i_item.page_size_code;
    assign w_bank      = VAL_W'(i_item.bank);

    always_comb begin
        if (w_in_action == ACT_MAP_PRG && i_item.bank < 0) begin
            w_base = w_bank + signed'(VAL_W'(w_adj));
        end else begin
            w_base = w_bank;
        end
    end

    assign w_val        = w_base <<< i_item.page_size_code;
    assign w_val_neg    = -w_val;
    assign w_span_end   = (SPAN_W'(i_item.slot) + SPAN_W'(1)) << i_item.page_size_code;
    assign w_span_first = SPAN_W'(i_item.slot) << i_item.page_size_code;

    always_comb begin
        if (w_in_action == ACT_MAP_PRG) begin
            w_map_ok = (i_item.page_size_code != PRG_CODE_BAD)
                    && (w_span_end <= SPAN_W'(PRG_WINDOW_SLOTS));
        end else begin
            w_map_ok = (w_span_end <= SPAN_W'(CHR_WINDOW_SLOTS));
        end
    end

    // One restoring step per cycle, then a wrap into the positive range
    assign w_div_ext  = REM_W'(r_div);
    assign w_rem_sh   = {r_rem[REM_W-2:0], r_mag[MAG_W-1]};
    assign w_rem_step = (w_rem_sh >= w_div_ext) ? (w_rem_sh - w_div_ext) : w_rem_sh;
    assign w_rem_inc  = r_rem + REM_W'(1);

    // Read translation from the latched word
    assign w_prg_sel = r_addr[ADDR_W-2:PRG_UNIT_W];
    assign w_chr_sel = r_addr[ADDR_W-1:CHR_UNIT_W];

    always_comb begin
        w_target = TGT_UNMAPPED;
        w_offset = '0;
        if (r_action == ACT_CPU_READ) begin
            priority if (r_addr >= PRG_BASE) begin
                if ({1'b0, w_prg_sel} < ($bits(w_prg_sel) + 1)'(PRG_WINDOW_SLOTS)) begin
                    w_target = TGT_PRG_ROM;
                    w_offset = OFFSET_W'({r_prg_tab[w_prg_sel[PRG_IDX_W-1:0]],
                                          r_addr[PRG_UNIT_W-1:0]});
                end
            end else if (r_addr >= RAM_BASE) begin
                w_target = TGT_PRG_RAM;
                w_offset = OFFSET_W'(r_addr - RAM_BASE);
            end else begin
                w_target = TGT_UNMAPPED;
            end
        end else begin
            if (w_chr_sel < $bits(w_chr_sel)'(CHR_WINDOW_SLOTS)) begin
                w_target = TGT_CHR;
                w_offset = OFFSET_W'({r_chr_tab[w_chr_sel[CHR_IDX_W-1:0]],
                                      r_addr[CHR_UNIT_W-1:0]});
            end
        end
    end

    assign w_out_free = !r_out_valid || o_result.ready;

    assign o_stat.in_is_read = (w_in_action == ACT_CPU_READ) || (w_in_action == ACT_CHR_READ);
    assign o_stat.map_ok     = r_map_ok;
    assign o_stat.div_last   = (r_step == STEP_W'(MAG_W - 1));
    assign o_stat.write_last = (r_left == LEFT_W'(1));
    assign o_stat.out_free   = w_out_free;

    assign i_cfg.ready     = 1'b1;
    assign o_result.valid  = r_out_valid;
    assign o_result.target = r_out_target;
    assign o_result.offset = r_out_offset;

    // Control state, size registers and window tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_banks <= CFG_W'(2);
            r_chr_banks <= CFG_W'(1);
            r_out_valid <= 1'b0;
            for (int i = 0; i < PRG_WINDOW_SLOTS; i++) begin
                r_prg_tab[i] <= '0;
            end
            for (int i = 0; i < CHR_WINDOW_SLOTS; i++) begin
                r_chr_tab[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_PRG_BANKS: r_prg_banks <= i_cfg.data;
                    CFG_CHR_BANKS: r_chr_banks <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.write_slot) begin
                if (r_is_prg) begin
                    r_prg_tab[r_wr_idx[PRG_IDX_W-1:0]] <= r_rem[PRG_ENT_W-1:0];
                end else begin
                    r_chr_tab[r_wr_idx[CHR_IDX_W-1:0]] <= r_rem[CHR_ENT_W-1:0];
                end
            end
        end
    end

    // Item latch, remainder unit and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action <= w_in_action;
            r_addr   <= i_item.address;
            r_is_prg <= (w_in_action == ACT_MAP_PRG);
            r_map_ok <= w_map_ok;
            r_mag    <= w_val[VAL_W-1] ? w_val_neg[MAG_W-1:0] : w_val[MAG_W-1:0];
            r_neg    <= w_val[VAL_W-1];
            r_div    <= (w_in_action == ACT_MAP_PRG) ? DIV_W'(w_prg_size)
                                                     : DIV_W'({w_chr_n, 3'b000});
            r_rem    <= '0;
            r_step   <= '0;
            r_wr_idx <= w_span_first[WR_IDX_W-1:0];
            r_left   <= LEFT_W'(1) << i_item.page_size_code;
        end
        if (i_cmd.div_step) begin
            r_rem  <= w_rem_step;
            r_mag  <= {r_mag[MAG_W-2:0], 1'b0};
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.fix) begin
            if (r_neg && r_rem != '0) begin
                r_rem <= w_div_ext - r_rem;
            end
        end
        if (i_cmd.write_slot) begin
            r_rem    <= (w_rem_inc == w_div_ext) ? '0 : w_rem_inc;
            r_wr_idx <= r_wr_idx + WR_IDX_W'(1);
            r_left   <= r_left - LEFT_W'(1);
        end
        if (i_cmd.load_out) begin
            r_out_target <= w_target;
            r_out_offset <= w_offset;
        end
    end

`ifndef SYNTH
    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write_slot |-> (r_rem < w_div_ext))
        else $error("window entry written with remainder not below ROM size");
`endif

endmodule

[rtl/cbam_ctrl.sv]
// Controller state machine: sequences item accept, result loads, remainder steps and table writes.
// Depends on cbam_pkg for the state, command and status types.
module cbam_ctrl import cbam_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = i_stat.in_is_read ? ST_READ : ST_DIV;
                end
            end
            ST_READ: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (!i_stat.map_ok) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_stat.div_last) begin
                        n_state = ST_FIX;
                    end
                end
            end
            ST_FIX: begin
                o_cmd.fix = 1'b1;
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.write_slot = 1'b1;
                if (i_stat.write_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_item, o_cmd.div_step, o_cmd.fix, o_cmd.write_slot,
                  o_cmd.load_out}))
        else $error("more than one datapath command in a cycle");
    a_load_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_stat.out_free)
        else $error("result loaded over a word not yet taken");
    a_write_after_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && $past(r_state) != ST_WRITE) |-> $past(r_state) == ST_FIX)
        else $error("table write entered without remainder fix");
`endif

endmodule

[rtl/cartridge_bank_address_mapper.sv]
// Top level of the cartridge bank address mapper: controller plus datapath.
// Depends on cbam_pkg, cbam_ifs.sv, cbam_ctrl and cbam_datapath.
//
// Bank-switching address translator. Each input word is either a map action
// (program or pattern window) or a read (CPU or pattern bus). A read is
// accepted, then, once the result register is free, the translated target and
// offset load into the result register, which holds the word until the sink
// takes it while the next input word is already accepted. A map action that
// is rejected (bad page code or slot beyond the window) ends without writes;
// otherwise the remainder unit wraps the bank into the ROM size one bit per
// cycle over 16 steps, a fix step follows, and there is one write per 8 KB or
// 1 KB entry the page covers (1 to 8) through the single write port
// of the window tables. Reset clears both tables at once in flip-flops,
// so there is no clearing pass. The two size registers take writes on the
// configuration channel at any time; write them only while the block is idle.
module cartridge_bank_address_mapper import cbam_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cbam_cfg_if.sink   i_cfg,
    cbam_in_if.sink    i_item,
    cbam_out_if.source o_result
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    // Hand the input ready to the channel
    assign i_item.ready = w_in_ready;

    cbam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cbam_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cfg    (i_cfg)
    );

endmodule

[bench/cartridge_bank_address_mapper_tb.sv]
// Self-checking bench for the cartridge bank address mapper: random and directed
// map and read words, checked against a local translation model.
// Depends on cbam_pkg, the channel interfaces in cbam_ifs.sv and the mapper RTL.
`timescale 1ns / 1ps

module cartridge_bank_address_mapper_tb import cbam_pkg::*; ();

    // Byte sizes of one table entry and of the ROM size units
    localparam longint PRG_PAGE_BYTES = 'h2000;
    localparam longint CHR_PAGE_BYTES = 'h400;
    localparam longint PRG_16K_BYTES  = 'h4000;
    localparam longint CHR_8K_BYTES   = 'h2000;

    // Margin so a trailing map word can finish before touching registers
    localparam int MAP_SETTLE   = 40;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int LIVE_PER_SET = 160;

    typedef struct {
        t_action                  action;
        logic [CODE_W-1:0]        code;
        logic [SLOT_W-1:0]        slot;
        logic signed [BANK_W-1:0] bank;
        logic [ADDR_W-1:0]        address;
    } t_cart_word;

    typedef struct {
        t_target             target;
        logic [OFFSET_W-1:0] offset;
    } t_xlat;

    logic i_clk;
    logic i_rst_n;

    cbam_cfg_if cfg_if ();
    cbam_in_if  item_if ();
    cbam_out_if res_if ();

    cartridge_bank_address_mapper i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_if),
        .i_item   (item_if),
        .o_result (res_if)
    );

    // Local copy of the size registers and both window tables
    logic [CFG_W-1:0]    rom_prg_16k;
    logic [CFG_W-1:0]    rom_chr_8k;
    logic [OFFSET_W-1:0] prg_page_base [PRG_WINDOW_SLOTS];
    logic [OFFSET_W-2:0] chr_page_base [CHR_WINDOW_SLOTS];

    t_cart_word pending_words [$];   // words waiting for the driver
    t_xlat      expected_xlat [$];   // translations owed by the block, oldest first

    int  fail_count = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;                // set: neither side idles

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Translation model
    // ------------------------------------------------------------------

    // True modulo: the result is never negative
    function automatic longint wrap_mod(longint v, longint m);
        longint r;
        r = v % m;
        if (r < 0) r += m;
        return r;
    endfunction

    // A size register of zero still means one unit
    function automatic longint prg_rom_bytes();
        longint n;
        n = (rom_prg_16k == '0) ? 1 : rom_prg_16k;
        return n * PRG_16K_BYTES;
    endfunction

    function automatic longint chr_mem_bytes();
        longint n;
        n = (rom_chr_8k == '0) ? 1 : rom_chr_8k;
        return n * CHR_8K_BYTES;
    endfunction

    // Reads always answer; a map word only acts with a good page code and a
    // page that fits inside the window
    function automatic bit word_has_effect(t_cart_word w);
        int units;
        units = 1 << w.code;
        if (w.action == ACT_MAP_PRG)
            return (w.code != PRG_CODE_BAD) && (units * (w.slot + 1) <= PRG_WINDOW_SLOTS);
        if (w.action == ACT_MAP_CHR)
            return units * (w.slot + 1) <= CHR_WINDOW_SLOTS;
        return 1'b1;
    endfunction

    function automatic void apply_map(t_cart_word w);
        longint rom;
        longint page;
        longint bnk;
        int     units;
        int     first;
        int     i;
        if (!word_has_effect(w)) return;
        units = 1 << w.code;
        first = units * w.slot;
        bnk   = w.bank;
        if (w.action == ACT_MAP_PRG) begin
            rom  = prg_rom_bytes();
            page = PRG_PAGE_BYTES << w.code;
            // Negative banks count back from the last bank, then still wrap
            if (bnk < 0) bnk += rom / page;
            for (i = 0; i < units; i++)
                prg_page_base[first + i] =
                    OFFSET_W'(wrap_mod(page * bnk + PRG_PAGE_BYTES * i, rom));
        end else begin
            rom  = chr_mem_bytes();
            page = CHR_PAGE_BYTES << w.code;
            for (i = 0; i < units; i++)
                chr_page_base[first + i] =
                    (OFFSET_W-1)'(wrap_mod(page * bnk + CHR_PAGE_BYTES * i, rom));
        end
    endfunction

    function automatic t_xlat translate(t_cart_word w);
        t_xlat r;
        int    idx;
        r.target = TGT_UNMAPPED;
        r.offset = '0;
        if (w.action == ACT_CPU_READ) begin
            if (w.address >= PRG_BASE) begin
                idx = int'((w.address - PRG_BASE) / PRG_PAGE_BYTES);
                if (idx < PRG_WINDOW_SLOTS) begin
                    r.target = TGT_PRG_ROM;
                    r.offset = prg_page_base[idx] + OFFSET_W'(w.address[12:0]);
                end
            end else if (w.address >= RAM_BASE) begin
                r.target = TGT_PRG_RAM;
                r.offset = OFFSET_W'(w.address - RAM_BASE);
            end
        end else begin
            idx = int'(w.address / CHR_PAGE_BYTES);
            if (idx < CHR_WINDOW_SLOTS) begin
                r.target = TGT_CHR;
                r.offset = OFFSET_W'(chr_page_base[idx]) + OFFSET_W'(w.address[9:0]);
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_cart_word make_word(t_action a, int code, int slot, int bank, int addr);
        t_cart_word w;
        w.action  = a;
        w.code    = CODE_W'(code);
        w.slot    = SLOT_W'(slot);
        w.bank    = BANK_W'(bank);
        w.address = ADDR_W'(addr);
        return w;
    endfunction

    // Mostly reads and well-placed maps; a few bad codes and slots past the window
    function automatic t_cart_word rand_word();
        t_cart_word w;
        int pick;
        int units;
        int slots;
        int b;
        pick = $urandom_range(99);
        w.action = (pick < 12) ? ACT_MAP_PRG :
                   (pick < 25) ? ACT_MAP_CHR :
                   (pick < 65) ? ACT_CPU_READ : ACT_CHR_READ;
        w.code = CODE_W'($urandom_range(3));
        if (w.action == ACT_MAP_PRG && $urandom_range(9) != 0)
            w.code = CODE_W'($urandom_range(2));
        units = 1 << w.code;
        slots = (w.action == ACT_MAP_PRG) ? PRG_WINDOW_SLOTS : CHR_WINDOW_SLOTS;
        if (units <= slots && $urandom_range(9) != 0)
            w.slot = SLOT_W'($urandom_range(slots / units - 1));
        else
            w.slot = SLOT_W'($urandom_range(7));
        case ($urandom_range(3))
            0: b = $urandom_range(15);
            1: b = -int'($urandom_range(8, 1));
            default: b = $urandom_range(8191);
        endcase
        w.bank = BANK_W'(b);
        if (w.action == ACT_CHR_READ)
            w.address = ($urandom_range(4) == 0) ? ADDR_W'($urandom_range(16'hFFFF))
                                                 : ADDR_W'($urandom_range(16'h1FFF));
        else
            w.address = ($urandom_range(3) == 0) ? ADDR_W'($urandom_range(16'hFFFF))
                                                 : ADDR_W'($urandom_range(16'hFFFF, 16'h6000));
        return w;
    endfunction

    // Wait until every word is taken and answered, then let a trailing map finish
    task automatic drain();
        while (pending_words.size() != 0 || item_if.valid) @(posedge i_clk);
        while (expected_xlat.size() != 0) @(posedge i_clk);
        repeat (MAP_SETTLE) @(posedge i_clk);
    endtask

    // Write both size registers back to back; only call while the block is idle
    task automatic set_sizes(logic [CFG_W-1:0] prg, logic [CFG_W-1:0] chr);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_PRG_BANKS;
        cfg_if.data  <= prg;
        do @(posedge i_clk); while (!cfg_if.ready);
        rom_prg_16k = prg;
        cfg_if.index <= CFG_CHR_BANKS;
        cfg_if.data  <= chr;
        do @(posedge i_clk); while (!cfg_if.ready);
        rom_chr_8k = chr;
        cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Input driver: present queued words, predict on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : word_driver
        t_cart_word cur_word;
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            // Commit the word the block just took to the model
            if (item_if.valid && item_if.ready) begin
                if (cur_word.action == ACT_MAP_PRG || cur_word.action == ACT_MAP_CHR)
                    apply_map(cur_word);
                else
                    expected_xlat.push_back(translate(cur_word));
            end
            // Hold a stalled word; otherwise advance or idle
            if (!item_if.valid || item_if.ready) begin
                if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
                    cur_word = pending_words.pop_front();
                    item_if.action         <= cur_word.action;
                    item_if.page_size_code <= cur_word.code;
                    item_if.slot           <= cur_word.slot;
                    item_if.bank           <= cur_word.bank;
                    item_if.address        <= cur_word.address;
                    item_if.valid          <= 1'b1;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each taken word with the oldest translation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_xlat want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_xlat.size() == 0) begin
                    $error("result with nothing owed: target %0d offset 0x%0h",
                           res_if.target, res_if.offset);
                    fail_count++;
                end else begin
                    want = expected_xlat.pop_front();
                    if (res_if.target !== want.target) begin
                        $error("target: expected %0d, actual %0d", want.target, res_if.target);
                        fail_count++;
                    end
                    if (res_if.offset !== want.offset) begin
                        $error("offset: expected 0x%0h, actual 0x%0h",
                               want.offset, res_if.offset);
                        fail_count++;
                    end
                end
            end
            // Stall the block at random, except in the calm stretch
            res_if.ready <= calm || ($urandom_range(99) >= 33);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: reset, directed words, then random sets under several sizes
    // ------------------------------------------------------------------
    initial begin : sequencer
        int           set_no;
        int           n_live;
        t_cart_word   w;
        logic [CFG_W-1:0] prg_sz;
        logic [CFG_W-1:0] chr_sz;

        // Drive every input to a known value before the first edge
        i_rst_n              = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_PRG_BANKS;
        cfg_if.data          = '0;
        item_if.valid        = 1'b0;
        item_if.action       = ACT_CPU_READ;
        item_if.page_size_code = '0;
        item_if.slot         = '0;
        item_if.bank         = '0;
        item_if.address      = '0;
        res_if.ready         = 1'b0;

        // Model starts from the reset sizes and cleared tables
        rom_prg_16k = 8'd2;
        rom_chr_8k  = 8'd1;
        foreach (prg_page_base[i]) prg_page_base[i] = '0;
        foreach (chr_page_base[i]) chr_page_base[i] = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reads on cleared tables: unmapped, RAM bounds, ROM and pattern bounds
        pending_words.push_back(make_word(ACT_CPU_READ, 0, 0, 0, 16'h0000));
        pending_words.push_back(make_word(ACT_CPU_READ, 3, 7, -1, 16'h5FFF));
        pending_words.push_back(make_word(ACT_CPU_READ, 0, 0, 0, 16'h6000));
        pending_words.push_back(make_word(ACT_CPU_READ, 0, 0, 0, 16'h7FFF));
        pending_words.push_back(make_word(ACT_CPU_READ, 0, 0, 0, 16'h8000));
        pending_words.push_back(make_word(ACT_CHR_READ, 0, 0, 0, 16'h2000));
        pending_words.push_back(make_word(ACT_CHR_READ, 0, 0, 0, 16'hFFFF));
        // Program maps: bad page code, slot past the window, negative banks,
        // a bank that stays negative after counting back, the largest bank
        pending_words.push_back(make_word(ACT_MAP_PRG, 3, 0, 1, 0));
        pending_words.push_back(make_word(ACT_MAP_PRG, 2, 1, 1, 0));
        pending_words.push_back(make_word(ACT_MAP_PRG, 0, 3, -1, 0));
        pending_words.push_back(make_word(ACT_MAP_PRG, 1, 0, 4095, 0));
        pending_words.push_back(make_word(ACT_MAP_PRG, 0, 2, -1024, 0));
        pending_words.push_back(make_word(ACT_CPU_READ, 0, 0, 0, 16'h8000));
        pending_words.push_back(make_word(ACT_CPU_READ, 0, 0, 0, 16'hA123));
        pending_words.push_back(make_word(ACT_CPU_READ, 0, 0, 0, 16'hDFFF));
        pending_words.push_back(make_word(ACT_CPU_READ, 0, 0, 0, 16'hFFFF));
        // Pattern maps: every page size, slot past the window, negative banks
        pending_words.push_back(make_word(ACT_MAP_CHR, 3, 0, -1, 0));
        pending_words.push_back(make_word(ACT_MAP_CHR, 0, 7, 4095, 0));
        pending_words.push_back(make_word(ACT_MAP_CHR, 2, 2, 3, 0));
        pending_words.push_back(make_word(ACT_MAP_CHR, 1, 3, -1024, 0));
        pending_words.push_back(make_word(ACT_MAP_PRG, 2, 0, -4096, 16'hFFFF));
        pending_words.push_back(make_word(ACT_CHR_READ, 0, 0, 0, 16'h0000));
        pending_words.push_back(make_word(ACT_CHR_READ, 0, 0, 0, 16'h1BFF));
        pending_words.push_back(make_word(ACT_CHR_READ, 0, 0, 0, 16'h1C00));
        pending_words.push_back(make_word(ACT_CHR_READ, 0, 0, 0, 16'h1FFF));
        pending_words.push_back(make_word(ACT_CPU_READ, 0, 0, 0, 16'hC000));
        drain();

        // Smallest sizes, largest sizes, zero program size, then random sizes.
        // Each set ends with the sender held off until every result is back.
        for (set_no = 0; set_no < 7; set_no++) begin
            case (set_no)
                0: begin prg_sz = 8'd1;   chr_sz = 8'd0;   end
                1: begin prg_sz = 8'd255; chr_sz = 8'd255; end
                2: begin prg_sz = 8'd0;   chr_sz = 8'd1;   end
                default: begin
                    prg_sz = CFG_W'($urandom_range(255));
                    chr_sz = CFG_W'($urandom_range(255));
                end
            endcase
            set_sizes(prg_sz, chr_sz);
            calm = (set_no == 3);
            n_live = 0;
            while (n_live < LIVE_PER_SET) begin
                w = rand_word();
                pending_words.push_back(w);
                if (word_has_effect(w)) n_live++;
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
